// ===== design/nec_pulse_width_frame_decoder_assert.svh =====
// Assertion macros used by the decode module of the infrared frame decoder.
`ifndef NEC_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH
`define NEC_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define NPWD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define NPWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nec_pwd_pkg.sv =====
// Shared types, constants and window compare for the infrared frame decoder.
package nec_pwd_pkg;

    localparam int TICKS_W     = 16;
    localparam int TOL_W       = 8;
    localparam int CODE_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CODE_BITS_DEFAULT = 32;

    localparam logic [TICKS_W-1:0] LEAD_REF_RESET  = 16'd135;
    localparam logic [TICKS_W-1:0] ONE_REF_RESET   = 16'd22;
    localparam logic [TICKS_W-1:0] ZERO_REF_RESET  = 16'd11;
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 8'd5;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEAD = 2'd1,
        STATUS_BAD_BIT  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEAD_REF  = 2'd0,
        REG_ONE_REF   = 2'd1,
        REG_ZERO_REF  = 2'd2,
        REG_TOLERANCE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [TICKS_W-1:0] lead_ref;
        logic [TICKS_W-1:0] one_ref;
        logic [TICKS_W-1:0] zero_ref;
        logic [TOL_W-1:0]   tolerance;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [TICKS_W-1:0] ticks;
        logic               start;
    } period_t;

    // Accept when the absolute distance from the reference is below the tolerance.
    function automatic logic in_window(
        input logic [TICKS_W-1:0] ticks,
        input logic [TICKS_W-1:0] ref_ticks,
        input logic [TOL_W-1:0]   tol
    );
        logic [TICKS_W-1:0] diff;
        begin
            diff = (ticks >= ref_ticks) ? (ticks - ref_ticks) : (ref_ticks - ticks);
            in_window = diff < {{(TICKS_W-TOL_W){1'b0}}, tol};
        end
    endfunction

endpackage

// ===== design/nec_pwd_cfg.sv =====
// Configuration register file: window references and tolerance.
module nec_pwd_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nec_pwd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nec_pwd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output nec_pwd_pkg::cfg_t                    cfg
);
    import nec_pwd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LEAD_REF:  cfg_next.lead_ref  = cfg_data;
                REG_ONE_REF:   cfg_next.one_ref   = cfg_data;
                REG_ZERO_REF:  cfg_next.zero_ref  = cfg_data;
                REG_TOLERANCE: cfg_next.tolerance = cfg_data[TOL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_ref  <= LEAD_REF_RESET;
            cfg_reg.one_ref   <= ONE_REF_RESET;
            cfg_reg.zero_ref  <= ZERO_REF_RESET;
            cfg_reg.tolerance <= TOLERANCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/nec_pwd_in_stage.sv =====
// Input register that holds one measured period until the decoder takes it.
module nec_pwd_in_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nec_pwd_pkg::TICKS_W-1:0]      s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 advance,
    output nec_pwd_pkg::period_t                 period
);
    import nec_pwd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [TICKS_W-1:0] ticks_reg;
    logic               start_reg;
    logic               load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ticks_reg <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    assign period.valid = valid_reg;
    assign period.ticks = ticks_reg;
    assign period.start = start_reg;

endmodule

// ===== design/nec_pwd_decode.sv =====
// Frame state, bit assembly and result register of the infrared frame decoder.
`include "nec_pulse_width_frame_decoder_assert.svh"

module nec_pwd_decode #(
    parameter int CODE_BITS = nec_pwd_pkg::CODE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nec_pwd_pkg::cfg_t                    cfg,
    input  nec_pwd_pkg::period_t                 period,
    output logic                                 advance,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [nec_pwd_pkg::CODE_W-1:0]       m_tdata,
    output logic [nec_pwd_pkg::STATUS_W-1:0]     m_tuser
);
    import nec_pwd_pkg::*;

    localparam int CNT_W = $clog2(CODE_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(CODE_BITS - 1);

    logic                 active_reg;
    logic                 active_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CODE_BITS-1:0] shift_reg;
    logic [CODE_BITS-1:0] shift_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CODE_W-1:0]    out_code_reg;
    status_t              out_status_reg;

    logic                 lead_ok;
    logic                 one_ok;
    logic                 zero_ok;
    logic                 bit_val;
    logic [CODE_BITS-1:0] shift_in;
    logic [CODE_W-1:0]    code_low;
    logic                 emit;
    logic [CODE_W-1:0]    emit_code;
    status_t              emit_status;

    assign advance  = period.valid && (!out_valid_reg || m_tready);

    assign lead_ok  = in_window(period.ticks, cfg.lead_ref, cfg.tolerance);
    assign one_ok   = in_window(period.ticks, cfg.one_ref, cfg.tolerance);
    assign zero_ok  = in_window(period.ticks, cfg.zero_ref, cfg.tolerance);
    // A period inside both windows counts as a one.
    assign bit_val  = one_ok;
    assign shift_in = {shift_reg[CODE_BITS-2:0], bit_val};

    generate
        if (CODE_BITS >= CODE_W)
        begin : g_code_trunc
            assign code_low = shift_in[CODE_W-1:0];
        end
        else
        begin : g_code_ext
            assign code_low = {{(CODE_W-CODE_BITS){1'b0}}, shift_in};
        end
    endgenerate

    // Next frame state.
    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        shift_next  = shift_reg;
        if (advance)
        begin
            priority if (period.start)
            begin
                active_next = lead_ok;
                count_next  = '0;
                shift_next  = '0;
            end
            else if (!active_reg)
            begin
                active_next = 1'b0;
            end
            else if (!(one_ok || zero_ok) || (count_reg == LAST_BIT))
            begin
                active_next = 1'b0;
                count_next  = '0;
                shift_next  = '0;
            end
            else
            begin
                count_next  = count_reg + 1'b1;
                shift_next  = shift_in;
            end
        end
    end

    // Result of the period in the input register.
    always_comb
    begin
        emit        = 1'b0;
        emit_code   = '0;
        emit_status = STATUS_OK;
        priority if (period.start)
        begin
            emit        = !lead_ok;
            emit_status = STATUS_BAD_LEAD;
        end
        else if (!active_reg)
        begin
            emit = 1'b0;
        end
        else if (!(one_ok || zero_ok))
        begin
            emit        = 1'b1;
            emit_status = STATUS_BAD_BIT;
        end
        else if (count_reg == LAST_BIT)
        begin
            emit        = 1'b1;
            emit_code   = code_low;
        end
        else
        begin
            emit = 1'b0;
        end
    end

    always_comb
    begin
        priority if (advance && emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            count_reg     <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_code_reg   <= emit_code;
            out_status_reg <= emit_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = out_status_reg;

    `NPWD_ASSERT_SAME(a_idle_clear, !active_reg, (count_reg == '0) && (shift_reg == '0), "idle decoder holds bit state")
    `NPWD_ASSERT_SAME(a_error_zero_code, out_valid_reg && (out_status_reg != STATUS_OK), out_code_reg == '0, "error result with nonzero code")
    `NPWD_ASSERT_NEXT(a_error_ends_frame, advance && emit && (emit_status != STATUS_OK), !active_reg, "frame still active after error")
    `NPWD_ASSERT_NEXT(a_done_ends_frame, advance && emit && (emit_status == STATUS_OK), !active_reg && (count_reg == '0), "frame still active after last bit")

endmodule

// ===== design/nec_pulse_width_frame_decoder.sv =====
// Top level of the pulse-distance infrared frame decoder.
// Each input transaction is one measured period in timer ticks; tuser marks the lead
// period of a new frame. The decoder takes one period every clock cycle while the result
// register is not stalled; a period passes through the input register, then the window
// compares and shift that load the result register. A frame is a lead period followed
// by CODE_BITS bit periods, first bit ending in the MSB; after the last bit the code
// comes out with status 0. A bad lead gives status 1, a bad bit status 2, both with
// code 0, and bit periods are then dropped until the next frame start. A period inside
// both bit windows counts as a one. A stalled result register stalls the input only
// when a new period actually has to move into the decode stage.
module nec_pulse_width_frame_decoder #(
    parameter int CODE_BITS = nec_pwd_pkg::CODE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nec_pwd_pkg::TICKS_W-1:0]      s_tdata,    // [15:0] pulse_ticks
    input  logic                                 s_tuser,    // [0] frame_start
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [nec_pwd_pkg::CODE_W-1:0]       m_tdata,    // [31:0] code
    output logic [nec_pwd_pkg::STATUS_W-1:0]     m_tuser,    // [1:0] status
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nec_pwd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nec_pwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nec_pwd_pkg::*;

    cfg_t    cfg;
    period_t period;
    logic    advance;

    nec_pwd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nec_pwd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .period   (period)
    );

    nec_pwd_decode #(
        .CODE_BITS (CODE_BITS)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .period   (period),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/tb_nec_pulse_width_frame_decoder.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the infrared pulse-distance frame decoder.
module tb_nec_pulse_width_frame_decoder;
    import nec_pwd_pkg::*;

    localparam int FRAME_BITS  = CODE_BITS_DEFAULT;
    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 23;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        status_t           status;
    } frame_result_t;

    // Tracks decoder state and the frames it still owes.
    class frame_decode_tracker;
        logic [TICKS_W-1:0] lead_ref;
        logic [TICKS_W-1:0] one_ref;
        logic [TICKS_W-1:0] zero_ref;
        logic [TOL_W-1:0]   tol;
        bit                 in_frame;
        int unsigned        bit_count;
        logic [63:0]        shift_reg;
        frame_result_t      pending_frames[$];
        int unsigned        frames_due;
        int unsigned        mismatches;

        function new();
            lead_ref   = LEAD_REF_RESET;
            one_ref    = ONE_REF_RESET;
            zero_ref   = ZERO_REF_RESET;
            tol        = TOLERANCE_RESET;
            in_frame   = 1'b0;
            bit_count  = 0;
            shift_reg  = '0;
            frames_due = 0;
            mismatches = 0;
        endfunction

        function bit near_ref(logic [TICKS_W-1:0] ticks, logic [TICKS_W-1:0] center);
            logic [TICKS_W-1:0] gap_ticks;
            gap_ticks = (ticks >= center) ? ticks - center : center - ticks;
            return int'(gap_ticks) < int'(tol);
        endfunction

        function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LEAD_REF:  lead_ref = data;
                REG_ONE_REF:   one_ref  = data;
                REG_ZERO_REF:  zero_ref = data;
                REG_TOLERANCE: tol      = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function void post(logic [CODE_W-1:0] code, status_t st);
            frame_result_t r;
            r.code   = code;
            r.status = st;
            pending_frames.push_back(r);
            frames_due++;
        endfunction

        // Returns 1 when the period changes anything, 0 when the decoder drops it.
        function bit take_period(logic [TICKS_W-1:0] ticks, logic start);
            logic bit_val;
            if (start)
            begin
                bit_count = 0;
                shift_reg = '0;
                in_frame  = near_ref(ticks, lead_ref);
                if (!in_frame)
                    post('0, STATUS_BAD_LEAD);
                return 1'b1;
            end
            if (!in_frame)
                return 1'b0;
            // a period inside both windows counts as a one
            if (near_ref(ticks, one_ref))
                bit_val = 1'b1;
            else if (near_ref(ticks, zero_ref))
                bit_val = 1'b0;
            else
            begin
                in_frame  = 1'b0;
                bit_count = 0;
                shift_reg = '0;
                post('0, STATUS_BAD_BIT);
                return 1'b1;
            end
            shift_reg = {shift_reg[62:0], bit_val};
            bit_count++;
            if (bit_count >= FRAME_BITS)
            begin
                post(shift_reg[CODE_W-1:0], STATUS_OK);
                in_frame  = 1'b0;
                bit_count = 0;
                shift_reg = '0;
            end
            return 1'b1;
        endfunction

        task flag(string msg);
            mismatches++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task match_frame(logic [CODE_W-1:0] code, logic [STATUS_W-1:0] st);
            frame_result_t want;
            if (pending_frames.size() == 0)
            begin
                flag($sformatf("unexpected result code=%h status=%0d", code, st));
                return;
            end
            want = pending_frames.pop_front();
            if (code !== want.code)
                flag($sformatf("code %h, want %h", code, want.code));
            if (st !== want.status)
                flag($sformatf("status %0d, want %0d", st, want.status));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TICKS_W-1:0]    s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CODE_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    frame_decode_tracker tracker;
    bit          steady;
    int unsigned live_periods;
    int unsigned cycle_count;

    nec_pulse_width_frame_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready = steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_frame(m_tdata, m_tuser);
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_period(input logic [TICKS_W-1:0] ticks, input logic start);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ticks;
        s_tuser  = start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (tracker.take_period(ticks, start))
            live_periods++;
        @(negedge clk);
    endtask

    task automatic write_cfg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_cfg(input logic [TICKS_W-1:0] lead, input logic [TICKS_W-1:0] one,
                            input logic [TICKS_W-1:0] zero, input logic [TOL_W-1:0] tol);
        write_cfg(REG_LEAD_REF, lead);
        write_cfg(REG_ONE_REF, one);
        write_cfg(REG_ZERO_REF, zero);
        // upper byte is don't-care for the tolerance register
        write_cfg(REG_TOLERANCE, {8'($urandom), tol});
    endtask

    // Hold until every frame is out, then let the pipeline flush dropped periods.
    task automatic drain();
        s_tvalid = 1'b0;
        while (tracker.pending_frames.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [TICKS_W-1:0] ticks_near(logic [TICKS_W-1:0] center);
        int tol_i;
        int off;
        int val;
        tol_i = tracker.tol;
        if (tol_i == 0)
            return center;
        off = ($urandom_range(0, 3) == 0) ? tol_i - 1 : $urandom_range(0, tol_i - 1);
        val = ($urandom_range(0, 1) != 0) ? int'(center) + off : int'(center) - off;
        if (val < 0 || val > 65535)
            val = (val < 0) ? int'(center) + off : int'(center) - off;
        return TICKS_W'(val);
    endfunction

    // Pick a period outside both windows, mostly right at a window edge.
    function automatic logic [TICKS_W-1:0] ticks_bad(logic [TICKS_W-1:0] a,
                                                     logic [TICKS_W-1:0] b);
        int val;
        logic [TICKS_W-1:0] center;
        for (int tries = 0; tries < 16; tries++)
        begin
            center = ($urandom_range(0, 1) != 0) ? a : b;
            case ($urandom_range(0, 2))
                0:       val = int'(center) + int'(tracker.tol);
                1:       val = int'(center) - int'(tracker.tol) - $urandom_range(0, 40);
                default: val = $urandom_range(0, 65535);
            endcase
            if (val < 0 || val > 65535)
                val = $urandom_range(0, 65535);
            if (!tracker.near_ref(TICKS_W'(val), a) && !tracker.near_ref(TICKS_W'(val), b))
                return TICKS_W'(val);
        end
        return TICKS_W'(val);
    endfunction

    task automatic run_frame();
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            // noise: random periods, now and then a frame start
            repeat ($urandom_range(1, 6))
                send_period(TICKS_W'($urandom), $urandom_range(0, 7) == 0);
            return;
        end
        if (kind < 25)
        begin
            send_period(ticks_bad(tracker.lead_ref, tracker.lead_ref), 1'b1);
            repeat ($urandom_range(0, 3))
                send_period(ticks_near(tracker.one_ref), 1'b0);
            return;
        end
        send_period(ticks_near(tracker.lead_ref), 1'b1);
        cut = $urandom_range(0, FRAME_BITS - 1);
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            // truncated frame: the next frame start drops it
            if (kind >= 75 && kind < 85 && i == cut)
                return;
            if (kind >= 85 && i == cut)
            begin
                send_period(ticks_bad(tracker.one_ref, tracker.zero_ref), 1'b0);
                repeat ($urandom_range(0, 2))
                    send_period(ticks_near(tracker.zero_ref), 1'b0);
                return;
            end
            if ($urandom_range(0, 1) != 0)
                send_period(ticks_near(tracker.one_ref), 1'b0);
            else
                send_period(ticks_near(tracker.zero_ref), 1'b0);
        end
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned live_base;
        int unsigned due_base;
        live_base = live_periods;
        due_base  = tracker.frames_due;
        while (live_periods - live_base < budget || tracker.frames_due - due_base < 6)
            run_frame();
        drain();
    endtask

    task automatic load_random_cfg();
        load_cfg(TICKS_W'($urandom), TICKS_W'($urandom), TICKS_W'($urandom),
                 TOL_W'($urandom_range(1, 255)));
    endtask

    initial
    begin
        logic [TICKS_W-1:0] zref;
        logic [TOL_W-1:0]   wide_tol;
        tracker      = new();
        steady       = 1'b0;
        live_periods = 0;
        cycle_count  = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at reset settings: lead 135, one 22, zero 11, tolerance 5.
        send_period(16'd22, 1'b0);      // bit with no frame: dropped
        send_period(16'd0, 1'b1);       // bad lead
        send_period(16'hFFFF, 1'b1);    // bad lead
        send_period(16'd130, 1'b1);     // lead right at the edge: bad
        send_period(16'd139, 1'b1);     // lead just inside
        send_period(16'd135, 1'b1);     // restart during a frame
        send_period(16'd18, 1'b0);      // one
        send_period(16'd15, 1'b0);      // zero
        send_period(16'd16, 1'b0);      // outside both windows: bad bit
        send_period(16'd22, 1'b0);      // dropped after the error
        send_period(16'd131, 1'b1);
        send_period(16'd26, 1'b0);
        send_period(16'd7, 1'b0);
        send_period(16'd22, 1'b0);
        send_period(16'd11, 1'b0);
        send_period(16'hFFFF, 1'b0);    // bad bit
        drain();

        run_phase(150);

        load_cfg(16'd0, 16'hFFFF, 16'd0, 8'd255);
        run_phase(150);

        load_cfg(16'hFFFF, 16'd0, 16'hFFFF, 8'd1);
        run_phase(150);

        // no idling on either side for this stretch
        steady = 1'b1;
        load_random_cfg();
        run_phase(200);
        steady = 1'b0;

        // overlapping bit windows
        wide_tol = TOL_W'($urandom_range(20, 255));
        zref     = TICKS_W'($urandom_range(0, 60000));
        load_cfg(TICKS_W'($urandom), zref + TICKS_W'($urandom_range(0, wide_tol)), zref,
                 wide_tol);
        run_phase(150);

        // zero tolerance: nothing is accepted
        load_cfg(TICKS_W'($urandom), TICKS_W'($urandom), TICKS_W'($urandom), 8'd0);
        run_phase(20);

        repeat (2)
        begin
            load_random_cfg();
            run_phase(150);
        end

        repeat (10) @(posedge clk);
        if (tracker.pending_frames.size() != 0)
            tracker.flag($sformatf("%0d frames never arrived", tracker.pending_frames.size()));
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
